// ===== rtl/bayq_pkg.sv =====
package bayq_pkg;

	localparam int MAX_WIDTH   = 4096;
	localparam int MAX_HEIGHT  = 4096;

	localparam int COORD_W     = 12;
	localparam int SAMP_W      = 10;
	localparam int DIM_W       = 13;
	localparam int ADDR_W      = 25;
	localparam int YUV_W       = 8;
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 40;
	localparam int CFG_IDX_W   = 2;
	localparam int SFMT_W      = 3;
	localparam int DFMT_W      = 4;

	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);

	// divide by 4000: >>5, then *ceil(2^22/125) >>22 (exact below 2^20)
	localparam int NUM_W       = 21;
	localparam int MAG_W       = 15;
	localparam int RCP_W       = 16;
	localparam int PROD_W      = MAG_W + RCP_W;
	localparam int PRE_SHIFT   = 5;
	localparam int RCP_SHIFT   = 22;
	localparam logic [RCP_W-1:0] RCP_125 = 16'd33555;

	localparam logic [CFG_IDX_W-1:0] REG_SRC_FMT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DST_FMT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 2'd3;

	localparam logic [DFMT_W-1:0] DST_BAYER10 = 4'd4;
	localparam logic [DFMT_W-1:0] DST_NV12    = 4'd8;
	localparam logic [DFMT_W-1:0] DST_YUYV    = 4'd9;
	localparam logic [DFMT_W-1:0] DST_UYVY    = 4'd10;

	localparam logic [1:0] PAT_RGGB = 2'd0;
	localparam logic [1:0] PAT_GRBG = 2'd1;
	localparam logic [1:0] PAT_GBRG = 2'd2;

	typedef enum logic [2:0] {
		KIND_BAYER8,
		KIND_BAYER10,
		KIND_NV12,
		KIND_YUYV,
		KIND_UYVY
	} kind_t;

	typedef logic [SAMP_W-1:0] samp_t;
	typedef samp_t [3:0] quad_t;

	typedef struct packed {
		samp_t r;
		samp_t gr;
		samp_t gb;
		samp_t b;
	} names_t;

	typedef struct packed {
		kind_t             kind;
		quad_t             pix;
		logic [YUV_W-1:0]  y_val;
		logic [YUV_W-1:0]  u_val;
		logic [YUV_W-1:0]  v_val;
		logic [ADDR_W-1:0] row0_addr;
		logic [ADDR_W-1:0] row1_addr;
		logic [ADDR_W-1:0] uv_addr;
	} desc_t;

	function automatic names_t names_from_quad(input logic [1:0] pat, input quad_t s);
		names_t n;
		case (pat)
			PAT_RGGB: begin n.r = s[0]; n.gr = s[1]; n.gb = s[2]; n.b = s[3]; end
			PAT_GRBG: begin n.gr = s[0]; n.r = s[1]; n.b = s[2]; n.gb = s[3]; end
			PAT_GBRG: begin n.gb = s[0]; n.b = s[1]; n.r = s[2]; n.gr = s[3]; end
			default:  begin n.b = s[0]; n.gb = s[1]; n.gr = s[2]; n.r = s[3]; end
		endcase
		return n;
	endfunction

	function automatic quad_t quad_from_names(input logic [1:0] pat, input names_t n);
		quad_t s;
		case (pat)
			PAT_RGGB: begin s[0] = n.r; s[1] = n.gr; s[2] = n.gb; s[3] = n.b; end
			PAT_GRBG: begin s[0] = n.gr; s[1] = n.r; s[2] = n.b; s[3] = n.gb; end
			PAT_GBRG: begin s[0] = n.gb; s[1] = n.b; s[2] = n.r; s[3] = n.gr; end
			default:  begin s[0] = n.b; s[1] = n.gb; s[2] = n.gr; s[3] = n.r; end
		endcase
		return s;
	endfunction

	function automatic logic [2:0] last_beat(input kind_t k);
		logic [2:0] lb;
		case (k)
			KIND_BAYER8, KIND_BAYER10: lb = 3'd3;
			KIND_NV12:                 lb = 3'd5;
			default:                   lb = 3'd7;
		endcase
		return lb;
	endfunction

endpackage

// ===== rtl/bayq_front.sv =====
module bayq_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [bayq_pkg::SFMT_W-1:0]      source_format,
	input  logic [bayq_pkg::DFMT_W-1:0]      dest_format,
	input  logic [bayq_pkg::DIM_W-1:0]       frame_width,
	input  logic [bayq_pkg::DIM_W-1:0]       frame_height,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [bayq_pkg::IN_TDATA_W-1:0]  in_data,
	output logic                             push,
	input  logic                             push_ready,
	output bayq_pkg::desc_t                  push_desc
);
	import bayq_pkg::*;

	logic en;

	// s1: input beat
	logic                 v_s1;
	logic [COORD_W-1:0]   x_s1, y_s1;
	quad_t                raw_s1;

	// s2: named colors, address products
	logic                 v_s2, keep_s2;
	kind_t                kind_s2;
	logic [SAMP_W-1:0]    r_s2, g_s2, b_s2;
	quad_t                pix_s2;
	logic [COORD_W-1:0]   x_s2;
	logic [ADDR_W-1:0]    yw_s2, yhw_s2, wh_s2;

	// s3: numerators, addresses
	logic                 v_s3, keep_s3;
	kind_t                kind_s3;
	quad_t                pix_s3;
	logic signed [NUM_W-1:0] ny_s3, nu_s3, nv_s3;
	logic [ADDR_W-1:0]    a0_s3, a1_s3, auv_s3;

	// s4: reciprocal products
	logic                 v_s4, keep_s4;
	kind_t                kind_s4;
	quad_t                pix_s4;
	logic                 nu_neg_s4, nv_neg_s4;
	logic [PROD_W-1:0]    py_s4, pu_s4, pv_s4;
	logic [ADDR_W-1:0]    a0_s4, a1_s4, auv_s4;

	// s5: finished descriptor
	logic                 v_s5, keep_s5;
	desc_t                desc_s5;

	quad_t                wide;
	names_t               nm;
	logic [SAMP_W:0]      gsum;
	kind_t                kind_c;
	logic                 keep_c;
	quad_t                pix_c;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			wide[i] = source_format[2] ? raw_s1[i] : {raw_s1[i][7:0], 2'b00};
		end
		nm     = names_from_quad(source_format[1:0], wide);
		gsum   = {1'b0, nm.gr} + {1'b0, nm.gb};
		pix_c  = quad_from_names(dest_format[1:0], nm);
		keep_c = 1'b1;
		kind_c = KIND_BAYER8;
		if (dest_format < DST_BAYER10) begin
			kind_c = KIND_BAYER8;
			for (int i = 0; i < 4; i++) begin
				pix_c[i] = {2'b00, pix_c[i][SAMP_W-1:2]};
			end
		end else if (dest_format < DST_NV12) begin
			kind_c = KIND_BAYER10;
		end else if (dest_format == DST_NV12) begin
			kind_c = KIND_NV12;
		end else if (dest_format == DST_YUYV) begin
			kind_c = KIND_YUYV;
		end else if (dest_format == DST_UYVY) begin
			kind_c = KIND_UYVY;
		end else begin
			keep_c = 1'b0;
		end
	end

	logic signed [NUM_W-1:0] rs, gs, bs;
	logic [ADDR_W-1:0]       a0_c;

	always_comb begin
		rs   = NUM_W'(signed'({1'b0, r_s2}));
		gs   = NUM_W'(signed'({1'b0, g_s2}));
		bs   = NUM_W'(signed'({1'b0, b_s2}));
		a0_c = yw_s2 + ADDR_W'(x_s2);
	end

	logic [NUM_W-1:0] mag_y, mag_u, mag_v;

	always_comb begin
		mag_y = ny_s3[NUM_W-1] ? NUM_W'(-ny_s3) : NUM_W'(ny_s3);
		mag_u = nu_s3[NUM_W-1] ? NUM_W'(-nu_s3) : NUM_W'(nu_s3);
		mag_v = nv_s3[NUM_W-1] ? NUM_W'(-nv_s3) : NUM_W'(nv_s3);
	end

	function automatic logic [YUV_W-1:0] finish(input logic [PROD_W-1:0] p, input logic neg,
			input logic [YUV_W-1:0] ofs);
		logic [YUV_W-1:0]  q;
		logic signed [9:0] t;
		q = p[RCP_SHIFT +: YUV_W];
		t = neg ? 10'(signed'({2'b00, ofs})) - 10'(signed'({2'b00, q}))
		        : 10'(signed'({2'b00, ofs})) + 10'(signed'({2'b00, q}));
		if (t < 0) begin
			return '0;
		end else if (t > 10'sd255) begin
			return '1;
		end
		return t[YUV_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= in_data[COORD_W-1:0];
			y_s1   <= in_data[2*COORD_W-1:COORD_W];
			for (int i = 0; i < 4; i++) begin
				raw_s1[i] <= in_data[2*COORD_W + i*SAMP_W +: SAMP_W];
			end

			keep_s2 <= keep_c;
			kind_s2 <= kind_c;
			r_s2    <= nm.r;
			g_s2    <= gsum[SAMP_W:1];
			b_s2    <= nm.b;
			pix_s2  <= pix_c;
			x_s2    <= x_s1;
			yw_s2   <= ADDR_W'(y_s1 * frame_width);
			yhw_s2  <= ADDR_W'(y_s1[COORD_W-1:1] * frame_width);
			wh_s2   <= ADDR_W'(frame_width * frame_height);

			keep_s3 <= keep_s2;
			kind_s3 <= kind_s2;
			pix_s3  <= pix_s2;
			ny_s3   <= rs * 21'sd257 + gs * 21'sd504 + bs * 21'sd98;
			nu_s3   <= bs * 21'sd439 - rs * 21'sd148 - gs * 21'sd291;
			nv_s3   <= rs * 21'sd439 - gs * 21'sd368 - bs * 21'sd71;
			a0_s3   <= a0_c;
			a1_s3   <= a0_c + ADDR_W'(frame_width);
			auv_s3  <= wh_s2 + yhw_s2 + ADDR_W'({x_s2[COORD_W-1:1], 1'b0});

			keep_s4   <= keep_s3;
			kind_s4   <= kind_s3;
			pix_s4    <= pix_s3;
			nu_neg_s4 <= nu_s3[NUM_W-1];
			nv_neg_s4 <= nv_s3[NUM_W-1];
			py_s4     <= mag_y[PRE_SHIFT +: MAG_W] * RCP_125;
			pu_s4     <= mag_u[PRE_SHIFT +: MAG_W] * RCP_125;
			pv_s4     <= mag_v[PRE_SHIFT +: MAG_W] * RCP_125;
			a0_s4     <= a0_s3;
			a1_s4     <= a1_s3;
			auv_s4    <= auv_s3;

			keep_s5           <= keep_s4;
			desc_s5.kind      <= kind_s4;
			desc_s5.pix       <= pix_s4;
			desc_s5.y_val     <= finish(py_s4, 1'b0, 8'd16);
			desc_s5.u_val     <= finish(pu_s4, nu_neg_s4, 8'd128);
			desc_s5.v_val     <= finish(pv_s4, nv_neg_s4, 8'd128);
			desc_s5.row0_addr <= a0_s4;
			desc_s5.row1_addr <= a1_s4;
			desc_s5.uv_addr   <= auv_s4;
		end
	end

	assign push      = v_s5 && keep_s5;
	assign push_desc = desc_s5;
	assign en        = !v_s5 || !keep_s5 || push_ready;
	assign in_ready  = en;

	a_no_lost_push: assert property (@(posedge clk) disable iff (!arst_n)
		push && !push_ready |=> push && $stable(push_desc))
		else $error("front dropped a stalled descriptor");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s1) && $stable(v_s4))
		else $error("front pipeline moved while stalled");

	a_drop_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !keep_s5 |-> en && !push)
		else $error("unknown format reached the queue");

endmodule

// ===== rtl/bayq_fifo.sv =====
module bayq_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            push_ready,
	input  bayq_pkg::desc_t push_desc,
	output logic            pop_valid,
	input  logic            pop,
	output bayq_pkg::desc_t pop_desc
);
	import bayq_pkg::*;

	desc_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_PTR_W:0]   count_q;
	logic                  do_push, do_pop;

	assign push_ready = count_q != (FIFO_PTR_W+1)'(FIFO_DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_desc   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	a_count_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 || count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH) ||
		(FIFO_PTR_W)'(wr_ptr_q - rd_ptr_q) == count_q[FIFO_PTR_W-1:0])
		else $error("queue count out of step with pointers");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (FIFO_PTR_W+1)'(FIFO_DEPTH))
		else $error("queue overflow");

	a_pop_level: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop && !do_push |=> count_q == $past(count_q) - 1'b1)
		else $error("queue lost track on pop");

endmodule

// ===== rtl/bayq_back.sv =====
module bayq_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	output logic                             q_pop,
	input  bayq_pkg::desc_t                  q_desc,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [bayq_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                             m_tuser,
	output logic                             m_tlast
);
	import bayq_pkg::*;

	desc_t             cur_q;
	logic              cur_v_q;
	logic [2:0]        beat_q;
	logic              out_free, emit, is_last;
	logic [ADDR_W-1:0] base, addr;
	logic [SAMP_W-1:0] data;
	logic              word;

	assign out_free = !m_tvalid || m_tready;
	assign is_last  = beat_q == last_beat(cur_q.kind);
	assign emit     = cur_v_q && out_free;
	assign q_pop    = q_valid && (!cur_v_q || (emit && is_last));

	always_comb begin
		base = beat_q[1] ? cur_q.row1_addr : cur_q.row0_addr;
		addr = base + ADDR_W'(beat_q[0]);
		data = cur_q.pix[beat_q[1:0]];
		word = 1'b0;
		case (cur_q.kind)
			KIND_BAYER8: begin
			end
			KIND_BAYER10: begin
				addr = {base[ADDR_W-2:0], 1'b0} + ADDR_W'({beat_q[0], 1'b0});
				word = 1'b1;
			end
			KIND_NV12: begin
				data = SAMP_W'(cur_q.y_val);
				if (beat_q[2]) begin
					addr = cur_q.uv_addr + ADDR_W'(beat_q[0]);
					data = SAMP_W'(beat_q[0] ? cur_q.v_val : cur_q.u_val);
				end
			end
			KIND_YUYV, KIND_UYVY: begin
				base = beat_q[2] ? cur_q.row1_addr : cur_q.row0_addr;
				addr = {base[ADDR_W-2:0], 1'b0} + ADDR_W'(beat_q[1:0]);
				if (beat_q[0] == (cur_q.kind == KIND_UYVY)) begin
					data = SAMP_W'(cur_q.y_val);
				end else begin
					data = SAMP_W'(beat_q[1] ? cur_q.v_val : cur_q.u_val);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q  <= 1'b0;
			beat_q   <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_v_q <= 1'b1;
				beat_q  <= '0;
			end else if (emit) begin
				if (is_last) begin
					cur_v_q <= 1'b0;
				end
				beat_q <= beat_q + 1'b1;
			end
			if (out_free) begin
				m_tvalid <= cur_v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_desc;
		end
		if (emit) begin
			m_tdata <= {(OUT_TDATA_W-ADDR_W-SAMP_W)'(0), data, addr};
			m_tuser <= word;
			m_tlast <= is_last;
		end
	end

	a_beat_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_v_q |-> beat_q <= last_beat(cur_q.kind))
		else $error("beat counter ran past the last write");

	a_pop_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from an empty queue");

	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> cur_v_q && beat_q == '0)
		else $error("new quad did not start at its first write");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		emit && is_last && !q_pop |=> !cur_v_q)
		else $error("quad kept running after its last write");

endmodule

// ===== rtl/bayer_quad_format_converter_unit.sv =====
// channel  | dir | tdata (low bit up)                          | tuser      | tlast
// s_axis   | in  | quad_col, quad_row, tl, tr, bl, br (64b)     | -          | -
// m_axis   | out | byte_addr, write_data, pad to 40b            | word_write | last_write
// cfg      | in  | cfg_we, cfg_index, cfg_wdata (13b)           | -          | -
//
// One quad gives 4 writes (Bayer), 6 (NV12) or 8 (YUYV/UYVY) at one write per
// cycle while m_tready is high; the output beat rate sets throughput.
// Five-stage front feeds a 4-entry descriptor queue; the back steps a beat counter.
// arst_n clears valid flags and sets config to its reset values.
// Output stall backs up the queue, then the front, then s_tready.
module bayer_quad_format_converter_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [bayq_pkg::IN_TDATA_W-1:0]  s_tdata,  // col, row, tl, tr, bl, br
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [bayq_pkg::OUT_TDATA_W-1:0] m_tdata,  // byte_addr, write_data, zero pad
	output logic                             m_tuser,  // word_write
	output logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic [bayq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bayq_pkg::DIM_W-1:0]       cfg_wdata
);
	import bayq_pkg::*;

	logic [SFMT_W-1:0] src_fmt_q;
	logic [DFMT_W-1:0] dst_fmt_q;
	logic [DIM_W-1:0]  width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_fmt_q <= '0;
			dst_fmt_q <= '0;
			width_q   <= DIM_W'(MAX_WIDTH);
			height_q  <= DIM_W'(MAX_HEIGHT);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SRC_FMT: src_fmt_q <= cfg_wdata[SFMT_W-1:0];
				REG_DST_FMT: dst_fmt_q <= cfg_wdata[DFMT_W-1:0];
				REG_WIDTH:   width_q   <= cfg_wdata > DIM_W'(MAX_WIDTH) ?
				                          DIM_W'(MAX_WIDTH) : cfg_wdata;
				REG_HEIGHT:  height_q  <= cfg_wdata > DIM_W'(MAX_HEIGHT) ?
				                          DIM_W'(MAX_HEIGHT) : cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	logic  push, push_ready, q_valid, q_pop;
	desc_t push_desc, q_desc;

	bayq_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.source_format (src_fmt_q),
		.dest_format   (dst_fmt_q),
		.frame_width   (width_q),
		.frame_height  (height_q),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_data       (s_tdata),
		.push          (push),
		.push_ready    (push_ready),
		.push_desc     (push_desc)
	);

	bayq_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_desc  (push_desc),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_desc   (q_desc)
	);

	bayq_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_desc   (q_desc),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
